// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/tsfl_pkg.sv -----
// ----------------------------------------------------------------------------
// tsfl_pkg
// Sizes, codes and request types of the two-sector key/value log.
// ----------------------------------------------------------------------------
package tsfl_pkg;

    localparam int SECTOR_BYTES      = 1024;
    localparam int SECTOR_HEAD_BYTES = 4;
    localparam int BUFFER_BYTES      = 64;
    localparam int REC_HEAD          = 4;
    localparam int MAX_OUT           = 60;

    localparam int SEC_AW   = $clog2(SECTOR_BYTES);
    localparam int FLASH_AW = SEC_AW + 1;
    localparam int OFF_W    = $clog2(SECTOR_BYTES + REC_HEAD + 65536);
    localparam int STG_AW   = $clog2(BUFFER_BYTES);
    localparam int STG_CW   = $clog2(BUFFER_BYTES + 1);

    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_LENGTH = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_FORMAT = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_RESERVED = 3'd2;
    localparam logic [2:0] ST_TOOLONG  = 3'd3;
    localparam logic [2:0] ST_NOSPACE  = 3'd4;
    localparam logic [2:0] ST_SMALL    = 3'd5;

    localparam logic [7:0] KEY_FREE   = 8'hFF;
    localparam logic [7:0] KEY_NONE   = 8'h00;
    localparam logic [7:0] FLAG_INUSE = 8'hAA;
    localparam logic [7:0] ERASED     = 8'hFF;

    typedef struct packed {
        logic             en;
        logic             sec;
        logic [OFF_W-1:0] off;
        logic [7:0]       data;
    } flash_wr_t;

    typedef struct packed {
        logic             sec;
        logic [OFF_W-1:0] off;
    } flash_rd_t;

endpackage

// ----- rtl/core/tsfl_flash.sv -----
// ----------------------------------------------------------------------------
// tsfl_flash
// Two-sector byte store: one write and one registered read port. Reads past
// the sector end return erased bytes; writes past it are dropped.
// ----------------------------------------------------------------------------
module tsfl_flash (
    input  logic                clk,
    input  tsfl_pkg::flash_wr_t wr,
    input  tsfl_pkg::flash_rd_t rd,
    output logic [7:0]          rd_data
);
    import tsfl_pkg::*;

    logic [7:0] mem [2*SECTOR_BYTES];
    logic [7:0] q_reg;
    logic       oob_reg;

    // write in range, read registered
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.off < OFF_W'(SECTOR_BYTES)))
        begin
            mem[{wr.sec, wr.off[SEC_AW-1:0]}] <= wr.data;
        end
        q_reg   <= mem[{rd.sec, rd.off[SEC_AW-1:0]}];
        oob_reg <= (rd.off >= OFF_W'(SECTOR_BYTES));
    end

    assign rd_data = oob_reg ? ERASED : q_reg;

endmodule

// ----- rtl/core/two_sector_flash_key_value_log_unit.sv -----
// ----------------------------------------------------------------------------
// two_sector_flash_key_value_log_unit
// Key/value record log over a two-sector byte store with compaction.
// ----------------------------------------------------------------------------
// Non-final write beats are staged while busy stays low.
// A command scans record headers, then reads out, appends or copies live
// records and erases a sector.
// Format sweeps both sectors. The store has a single read port and a single
// write port.
// After reset the block is busy while it clears the store.
module two_sector_flash_key_value_log_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  command,
    input  logic [7:0]  key,
    input  logic [15:0] length,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        busy,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [15:0] length_res,
    output logic [7:0]  data_byte_res,
    output logic        last_result
);
    import tsfl_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WIPE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_HDR  = 4'd3;
    localparam logic [3:0] S_EVAL = 4'd4;
    localparam logic [3:0] S_COPY = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;
    localparam logic [3:0] S_WREC = 4'd7;

    localparam logic [1:0] M_FIND    = 2'd0;
    localparam logic [1:0] M_APPEND  = 2'd1;
    localparam logic [1:0] M_COMPACT = 2'd2;

    localparam logic [1:0] W_RESET   = 2'd0;
    localparam logic [1:0] W_FORMAT  = 2'd1;
    localparam logic [1:0] W_COMPACT = 2'd2;

    localparam logic [OFF_W-1:0] HEAD_OFF = OFF_W'(SECTOR_HEAD_BYTES);
    localparam logic [OFF_W-1:0] SCAN_LIM = OFF_W'(SECTOR_BYTES - REC_HEAD);

    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [15:0] len;
        logic [7:0]  db;
        logic        last;
    } res_t;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          mode_reg, mode_next;
    logic [1:0]          wret_reg, wret_next;
    logic                sec_reg, sec_next;
    logic [OFF_W-1:0]    a_reg, a_next;
    logic [OFF_W-1:0]    d_reg, d_next;
    logic [2:0]          hcnt_reg, hcnt_next;
    logic                dirty_reg, dirty_next;
    logic                pass_reg, pass_next;
    logic [OFF_W-1:0]    cnt_reg, cnt_next;
    logic [OFF_W-1:0]    n_reg, n_next;
    logic [FLASH_AW-1:0] wipe_addr_reg, wipe_addr_next;
    logic [FLASH_AW-1:0] wipe_last_reg, wipe_last_next;
    logic                wipe_flag_reg, wipe_flag_next;
    logic [STG_CW-1:0]   staged_reg, staged_next;
    res_t                res_reg, res_next;

    logic [2:0]          cmd_reg, cmd_next;
    logic [7:0]          key_reg, key_next;
    logic [15:0]         len_reg, len_next;
    logic [7:0]          hk_reg, hk_next;
    logic [7:0]          hc_reg, hc_next;
    logic [15:0]         hl_reg, hl_next;
    logic [OFF_W-1:0]    at_reg, at_next;
    logic [15:0]         flen_reg, flen_next;

    logic [7:0]          stage_mem [BUFFER_BYTES];
    logic [7:0]          stage_q_reg;
    logic [STG_AW-1:0]   stage_rd_idx;
    logic                stage_we;

    flash_wr_t           wr;
    flash_rd_t           rd;
    logic [7:0]          rd_data;

    logic                end_scan;
    logic                live;
    logic [OFF_W-1:0]    step;
    logic [OFF_W-1:0]    wpos;

    tsfl_flash u_flash (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // stage write data, read staging for record append
    assign stage_we = !busy && start && (command == CMD_WRITE)
                      && (staged_reg < STG_CW'(BUFFER_BYTES));

    always_ff @(posedge clk)
    begin
        if (stage_we)
        begin
            stage_mem[staged_reg[STG_AW-1:0]] <= data_byte;
        end
        stage_q_reg <= stage_mem[stage_rd_idx];
    end

    assign live = (hk_reg != KEY_NONE) && (hc_reg == ~hk_reg);
    assign step = a_reg + OFF_W'(REC_HEAD) + OFF_W'(hl_reg);
    assign wpos = cnt_reg - OFF_W'(1);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        wret_next      = wret_reg;
        sec_next       = sec_reg;
        a_next         = a_reg;
        d_next         = d_reg;
        hcnt_next      = hcnt_reg;
        dirty_next     = dirty_reg;
        pass_next      = pass_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        wipe_addr_next = wipe_addr_reg;
        wipe_last_next = wipe_last_reg;
        wipe_flag_next = wipe_flag_reg;
        staged_next    = staged_reg;
        res_next       = '{valid: 1'b0, status: res_reg.status, len: res_reg.len,
                           db: res_reg.db, last: res_reg.last};
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        hk_next        = hk_reg;
        hc_next        = hc_reg;
        hl_next        = hl_reg;
        at_next        = at_reg;
        flen_next      = flen_reg;
        rd             = '{sec: sec_reg, off: a_reg};
        wr             = '{en: 1'b0, sec: sec_reg, off: a_reg, data: KEY_NONE};
        stage_rd_idx   = STG_AW'(cnt_reg - OFF_W'(REC_HEAD));
        end_scan       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (stage_we)
                    begin
                        staged_next = staged_reg + STG_CW'(1);
                    end
                    if (last)
                    begin
                        cmd_next = command;
                        key_next = key;
                        len_next = length;
                        if (command != CMD_WRITE)
                        begin
                            staged_next = '0;
                        end
                        case (command)
                            CMD_READ, CMD_LENGTH, CMD_WRITE, CMD_DELETE:
                            begin
                                if (key == KEY_NONE || key == KEY_FREE)
                                begin
                                    res_next    = '{1'b1, ST_RESERVED, 16'd0, 8'd0, 1'b1};
                                    staged_next = '0;
                                end
                                else if (command == CMD_WRITE &&
                                         ({1'b0, length} + 17'(REC_HEAD)) >
                                         17'(BUFFER_BYTES))
                                begin
                                    res_next    = '{1'b1, ST_TOOLONG, 16'd0, 8'd0, 1'b1};
                                    staged_next = '0;
                                end
                                else
                                begin
                                    mode_next  = M_FIND;
                                    a_next     = HEAD_OFF;
                                    state_next = S_SCAN;
                                end
                            end
                            CMD_FORMAT:
                            begin
                                wipe_addr_next = '0;
                                wipe_last_next = '1;
                                wipe_flag_next = 1'b0;
                                wret_next      = W_FORMAT;
                                sec_next       = 1'b1;
                                state_next     = S_WIPE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            S_WIPE:
            begin
                wr.en   = 1'b1;
                wr.sec  = wipe_addr_reg[FLASH_AW-1];
                wr.off  = OFF_W'(wipe_addr_reg[SEC_AW-1:0]);
                wr.data = (wipe_flag_reg && wipe_addr_reg == FLASH_AW'(SECTOR_BYTES))
                          ? FLAG_INUSE : ERASED;
                if (wipe_addr_reg == wipe_last_reg)
                begin
                    case (wret_reg)
                        W_FORMAT:
                        begin
                            res_next   = '{1'b1, ST_OK, 16'd0, 8'd0, 1'b1};
                            state_next = S_IDLE;
                        end
                        W_COMPACT:
                        begin
                            sec_next   = ~sec_reg;
                            mode_next  = M_APPEND;
                            pass_next  = 1'b1;
                            dirty_next = 1'b0;
                            a_next     = HEAD_OFF;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    wipe_addr_next = wipe_addr_reg + FLASH_AW'(1);
                end
            end

            S_SCAN:
            begin
                if (a_reg >= SCAN_LIM ||
                    (mode_reg == M_APPEND &&
                     (a_reg + OFF_W'(REC_HEAD) + OFF_W'(len_reg)) > OFF_W'(SECTOR_BYTES)))
                begin
                    end_scan = 1'b1;
                end
                else
                begin
                    hcnt_next  = '0;
                    state_next = S_HDR;
                end
            end

            S_HDR:
            begin
                rd.off    = a_reg + OFF_W'(hcnt_reg);
                hcnt_next = hcnt_reg + 3'd1;
                case (hcnt_reg)
                    3'd1: hk_next = rd_data;
                    3'd2: hc_next = rd_data;
                    3'd3: hl_next = {hl_reg[15:8], rd_data};
                    3'd4:
                    begin
                        hl_next    = {rd_data, hl_reg[7:0]};
                        state_next = S_EVAL;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_EVAL:
            begin
                if (hk_reg == KEY_FREE)
                begin
                    if (mode_reg == M_APPEND)
                    begin
                        cnt_next   = '0;
                        n_next     = OFF_W'(REC_HEAD) + OFF_W'(len_reg);
                        state_next = S_WREC;
                    end
                    else
                    begin
                        end_scan = 1'b1;
                    end
                end
                else
                begin
                    case (mode_reg)
                        M_FIND:
                        begin
                            if (live && hk_reg == key_reg)
                            begin
                                at_next   = a_reg;
                                flen_next = hl_reg;
                                state_next = S_IDLE;
                                case (cmd_reg)
                                    CMD_LENGTH:
                                    begin
                                        res_next = '{1'b1, ST_OK, hl_reg, 8'd0, 1'b1};
                                    end
                                    CMD_READ:
                                    begin
                                        if (len_reg < hl_reg)
                                        begin
                                            res_next = '{1'b1, ST_SMALL, hl_reg, 8'd0, 1'b1};
                                        end
                                        else if (hl_reg == 16'd0)
                                        begin
                                            res_next = '{1'b1, ST_OK, 16'd0, 8'd0, 1'b1};
                                        end
                                        else
                                        begin
                                            cnt_next   = '0;
                                            n_next     = (hl_reg < 16'(MAX_OUT))
                                                         ? OFF_W'(hl_reg) : OFF_W'(MAX_OUT);
                                            state_next = S_OUT;
                                        end
                                    end
                                    CMD_DELETE:
                                    begin
                                        wr       = '{1'b1, sec_reg, a_reg + OFF_W'(1), KEY_NONE};
                                        res_next = '{1'b1, ST_OK, 16'd0, 8'd0, 1'b1};
                                    end
                                    default:
                                    begin
                                        // drop the old copy, then append
                                        wr         = '{1'b1, sec_reg, a_reg + OFF_W'(1),
                                                       KEY_NONE};
                                        mode_next  = M_APPEND;
                                        pass_next  = 1'b0;
                                        dirty_next = 1'b0;
                                        a_next     = HEAD_OFF;
                                        state_next = S_SCAN;
                                    end
                                endcase
                            end
                            else
                            begin
                                a_next     = step;
                                state_next = S_SCAN;
                            end
                        end
                        M_APPEND:
                        begin
                            if (!live)
                            begin
                                dirty_next = 1'b1;
                            end
                            a_next     = step;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            if (live)
                            begin
                                cnt_next   = '0;
                                n_next     = OFF_W'(REC_HEAD) + OFF_W'(hl_reg);
                                state_next = S_COPY;
                            end
                            else
                            begin
                                a_next     = step;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_COPY:
            begin
                rd.off = a_reg + cnt_reg;
                if (cnt_reg != '0)
                begin
                    wr = '{1'b1, ~sec_reg, d_reg + wpos, rd_data};
                end
                if (cnt_reg == n_reg)
                begin
                    a_next     = a_reg + n_reg;
                    d_next     = d_reg + n_reg;
                    state_next = S_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + OFF_W'(1);
                end
            end

            S_OUT:
            begin
                rd.off = at_reg + OFF_W'(REC_HEAD) + cnt_reg;
                if (cnt_reg != '0)
                begin
                    res_next = '{1'b1, ST_OK, flen_reg, rd_data, cnt_reg == n_reg};
                end
                if (cnt_reg == n_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + OFF_W'(1);
                end
            end

            S_WREC:
            begin
                if (cnt_reg != '0)
                begin
                    wr.en  = 1'b1;
                    wr.off = a_reg + wpos;
                    if (wpos == OFF_W'(0))
                    begin
                        wr.data = key_reg;
                    end
                    else if (wpos == OFF_W'(1))
                    begin
                        wr.data = ~key_reg;
                    end
                    else if (wpos == OFF_W'(2))
                    begin
                        wr.data = len_reg[7:0];
                    end
                    else if (wpos == OFF_W'(3))
                    begin
                        wr.data = len_reg[15:8];
                    end
                    else if ((wpos - OFF_W'(REC_HEAD)) < OFF_W'(staged_reg))
                    begin
                        wr.data = stage_q_reg;
                    end
                    else
                    begin
                        wr.data = KEY_NONE;
                    end
                end
                if (cnt_reg == n_reg)
                begin
                    res_next    = '{1'b1, ST_OK, 16'd0, 8'd0, 1'b1};
                    staged_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + OFF_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // close a header scan that ran out of records or space
        if (end_scan)
        begin
            case (mode_reg)
                M_FIND:
                begin
                    if (cmd_reg == CMD_WRITE)
                    begin
                        mode_next  = M_APPEND;
                        pass_next  = 1'b0;
                        dirty_next = 1'b0;
                        a_next     = HEAD_OFF;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_next   = '{1'b1, ST_NOTFOUND, 16'd0, 8'd0, 1'b1};
                        state_next = S_IDLE;
                    end
                end
                M_APPEND:
                begin
                    if (dirty_reg && !pass_reg)
                    begin
                        mode_next  = M_COMPACT;
                        a_next     = HEAD_OFF;
                        d_next     = HEAD_OFF;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_next    = '{1'b1, ST_NOSPACE, 16'd0, 8'd0, 1'b1};
                        staged_next = '0;
                        state_next  = S_IDLE;
                    end
                end
                default:
                begin
                    // flag the new sector, then erase the old one
                    wr             = '{1'b1, ~sec_reg, OFF_W'(0), FLAG_INUSE};
                    wipe_addr_next = {sec_reg, {SEC_AW{1'b0}}};
                    wipe_last_next = {sec_reg, {SEC_AW{1'b1}}};
                    wipe_flag_next = 1'b0;
                    wret_next      = W_COMPACT;
                    state_next     = S_WIPE;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WIPE;
            mode_reg      <= M_FIND;
            wret_reg      <= W_RESET;
            sec_reg       <= 1'b1;
            a_reg         <= '0;
            d_reg         <= '0;
            hcnt_reg      <= '0;
            dirty_reg     <= 1'b0;
            pass_reg      <= 1'b0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            wipe_addr_reg <= '0;
            wipe_last_reg <= '1;
            wipe_flag_reg <= 1'b1;
            staged_reg    <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            wret_reg      <= wret_next;
            sec_reg       <= sec_next;
            a_reg         <= a_next;
            d_reg         <= d_next;
            hcnt_reg      <= hcnt_next;
            dirty_reg     <= dirty_next;
            pass_reg      <= pass_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            wipe_addr_reg <= wipe_addr_next;
            wipe_last_reg <= wipe_last_next;
            wipe_flag_reg <= wipe_flag_next;
            staged_reg    <= staged_next;
            res_reg       <= res_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        len_reg  <= len_next;
        hk_reg   <= hk_next;
        hc_reg   <= hc_next;
        hl_reg   <= hl_next;
        at_reg   <= at_next;
        flen_reg <= flen_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = res_reg.valid;
    assign status        = res_reg.status;
    assign length_res    = res_reg.len;
    assign data_byte_res = res_reg.db;
    assign last_result   = res_reg.last;

endmodule

// ----- rtl/core/tsfl_checker.sv -----
// ----------------------------------------------------------------------------
// tsfl_checker
// Port-level checks on the key/value log's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsfl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] command,
    input logic       last,
    input logic       result_valid,
    input logic [2:0] status,
    input logic       last_result
);
    import tsfl_pkg::*;

    `ASSERT_IMP(res_status_range, clk, rst_n, result_valid, status <= ST_SMALL)
    `ASSERT_IMP(err_is_final, clk, rst_n, result_valid && status != ST_OK, last_result)
    `ASSERT_NXT(burst_continues, clk, rst_n, result_valid && !last_result, result_valid)
    `ASSERT_NXT(format_goes_busy, clk, rst_n, start && !busy && last && command == CMD_FORMAT, busy)

endmodule

bind two_sector_flash_key_value_log_unit tsfl_checker u_tsfl_checker (.*);
